/* rtl/core/calendar_day_number_converter_top_assert.svh */
// Assertion macros shared by the checker of the day-number converter.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef CALENDAR_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH
`define CALENDAR_DAY_NUMBER_CONVERTER_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define CDN_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("cdn assertion failed");

// An implication checked at every clock edge outside reset.
`define CDN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("cdn assertion failed");

`endif

/* rtl/core/cdn_pkg.sv */
`default_nettype none

package cdn_pkg;

  localparam int unsigned DayW         = 22;
  localparam int unsigned YearW        = 14;
  localparam int unsigned ShortYearInW = 7;
  localparam int unsigned MonthW       = 4;
  localparam int unsigned MdayW        = 5;
  localparam int unsigned ShortW       = 7;
  localparam int unsigned WdayW        = 3;

  localparam logic [DayW-1:0] DayMax = '1;

  localparam int unsigned Days200          = 73049;
  localparam int unsigned Days4            = 1461;
  localparam int unsigned Days1            = 365;
  localparam int unsigned ShiftYears       = 199;
  localparam int unsigned CenturyBase      = 1900;
  localparam int unsigned WeekStart        = 1;
  localparam int unsigned YearsPerCycle    = 200;
  localparam int unsigned YearsPerLeap     = 4;
  localparam int unsigned YearsPerCentury  = 100;
  localparam int unsigned MonthsPerYear    = 12;
  localparam int unsigned YearBias         = Days200 - Days1;

  // Exact division by constants: x / d == (x * ceil(2^k / d)) >> k for the
  // stated input width, with k the input width plus the bit length of d.
  localparam int unsigned RestW        = 23;
  localparam int unsigned C200W        = 6;
  localparam int unsigned C200Shift    = 40;
  localparam int unsigned C200RecipW   = 24;
  localparam longint unsigned C200Recip = ((64'd1 << C200Shift) + Days200 - 1) / Days200;

  localparam int unsigned Rest2W       = 17;
  localparam int unsigned C4W          = 6;
  localparam int unsigned C4Shift      = 28;
  localparam int unsigned C4RecipW     = 18;
  localparam longint unsigned C4Recip = ((64'd1 << C4Shift) + Days4 - 1) / Days4;

  localparam int unsigned Rest3W       = 11;
  localparam int unsigned DoyW         = 9;

  localparam int unsigned ShiftYearW   = 15;
  localparam int unsigned Q200W        = 7;
  localparam int unsigned Y200Shift    = 23;
  localparam int unsigned Y200RecipW   = 16;
  localparam longint unsigned Y200Recip =
    ((64'd1 << Y200Shift) + YearsPerCycle - 1) / YearsPerCycle;

  localparam int unsigned Y100Shift    = 21;
  localparam int unsigned Y100RecipW   = 15;
  localparam longint unsigned Y100Recip =
    ((64'd1 << Y100Shift) + YearsPerCentury - 1) / YearsPerCentury;

  localparam int unsigned DecStages = 8;
  localparam int unsigned EncStages = 4;
  localparam int unsigned Latency   = DecStages + 1;

  typedef enum logic {
    KindToDate = 1'b0,
    KindToDays = 1'b1
  } cdn_kind_e;

  typedef struct packed {
    logic [DayW-1:0]   day_count;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [MdayW-1:0]  mday;
    logic [ShortW-1:0] short_year;
    logic [WdayW-1:0]  weekday;
  } cdn_date_t;

  typedef struct packed {
    logic [DayW-1:0]  day_count;
    logic [YearW-1:0] year;
  } cdn_days_t;

  // Days in the months before month index idx (0 is January).
  function automatic logic [DoyW-1:0] cum_days(input logic leap, input logic [MonthW-1:0] idx);
    logic [DoyW-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + ((leap && (idx >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/calendar_day_number_converter_top.sv */
`default_nettype none

// Converts a day number (day 0 is 1 January of year 0, leap years every
// fourth year except multiples of 200) into year, month, day of month,
// two-digit year and weekday, or a year, month and day into a day number,
// as selected by kind_i. A command is taken whenever start_i is high; busy_o
// never rises, so a new command may be issued in every cycle. The result of
// each command appears on the output ports for exactly one cycle with done_o
// high, once it has passed the pipeline and output register, and results
// leave in command order. The receiver cannot hold a result off, so
// it must take every transfer that done_o marks. The decode pipeline sets the
// latency; it divides by the 200-year and 4-year cycle lengths with two
// chained reciprocal multipliers; the encode path is delayed to match.
module calendar_day_number_converter_top
  import cdn_pkg::*;
#(
  parameter int unsigned MaxYear = 9999
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    kind_i,
  input  logic [DayW-1:0]         day_number_i,
  input  logic [YearW-1:0]        year_in_i,
  input  logic [ShortYearInW-1:0] short_year_in_i,
  input  logic [MonthW-1:0]       month_in_i,
  input  logic [MdayW-1:0]        mday_in_i,
  output logic                    done_o,
  output logic [DayW-1:0]         day_count_o,
  output logic [YearW-1:0]        year_out_o,
  output logic [MonthW-1:0]       month_out_o,
  output logic [MdayW-1:0]        mday_out_o,
  output logic [ShortW-1:0]       short_year_out_o,
  output logic [WdayW-1:0]        weekday_o
);

  logic                 accept;
  logic [DecStages-1:0] vld_d, vld_q;
  cdn_kind_e            kind_q [DecStages];
  cdn_date_t            dec_date;
  cdn_days_t            enc_days;
  cdn_date_t            out_d, out_q;
  logic                 done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign vld_d  = {vld_q[DecStages-2:0], accept};

  cdn_decode #(
    .MaxYear(MaxYear)
  ) u_decode (
    .clk_i       (clk_i),
    .day_number_i(day_number_i),
    .date_o      (dec_date)
  );

  cdn_encode #(
    .MaxYear(MaxYear)
  ) u_encode (
    .clk_i          (clk_i),
    .year_in_i      (year_in_i),
    .short_year_in_i(short_year_in_i),
    .month_in_i     (month_in_i),
    .mday_in_i      (mday_in_i),
    .days_o         (enc_days)
  );

  always_comb begin
    out_d = dec_date;
    if (kind_q[DecStages-1] == KindToDays) begin
      out_d            = '0;
      out_d.day_count  = enc_days.day_count;
      out_d.year       = enc_days.year;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[DecStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[0] <= cdn_kind_e'(kind_i);
    for (int i = 1; i < DecStages; i++) begin
      kind_q[i] <= kind_q[i-1];
    end
    out_q <= out_d;
  end

  assign done_o           = done_q;
  assign day_count_o      = out_q.day_count;
  assign year_out_o       = out_q.year;
  assign month_out_o      = out_q.month;
  assign mday_out_o       = out_q.mday;
  assign short_year_out_o = out_q.short_year;
  assign weekday_o        = out_q.weekday;

endmodule

`default_nettype wire

/* rtl/core/cdn_decode.sv */
`default_nettype none

module cdn_decode
  import cdn_pkg::*;
#(
  parameter int unsigned MaxYear = 9999
) (
  input  logic            clk_i,
  input  logic [DayW-1:0] day_number_i,
  output cdn_date_t       date_o
);

  localparam longint unsigned LastShift = 64'(MaxYear) + 64'd1 + 64'(ShiftYears);
  localparam longint unsigned LastRaw   = LastShift * Days1 + LastShift / 4
                                          - LastShift / YearsPerCycle - YearBias - 1;
  localparam logic [DayW-1:0] LastDay   = (LastRaw > 64'(DayMax)) ? DayMax : DayW'(LastRaw);
  localparam int unsigned OctDigits = (RestW + 2) / 3;
  localparam int unsigned WkW       = 3 * OctDigits;
  localparam int unsigned WsumW     = 6;
  localparam int unsigned YearCalcW = 16;

  logic [DayW-1:0]   s1_dn_d, s1_dn_q;
  logic [RestW-1:0]  s1_rest_d, s1_rest_q;

  logic [DayW-1:0]   s2_dn_q;
  logic [RestW-1:0]  s2_rest_q;
  logic [C200W-1:0]  s2_c200_d, s2_c200_q;
  logic [WsumW-1:0]  s2_wsum_d, s2_wsum_q;

  logic [DayW-1:0]   s3_dn_q;
  logic [C200W-1:0]  s3_c200_q;
  logic [Rest2W-1:0] s3_rest2_d, s3_rest2_q;
  logic [3:0]        s3_wfold_d, s3_wfold_q;

  logic [DayW-1:0]   s4_dn_q;
  logic [C200W-1:0]  s4_c200_q;
  logic [Rest2W-1:0] s4_rest2_q;
  logic [C4W-1:0]    s4_c4_d, s4_c4_q;
  logic [WdayW-1:0]  s4_wd_d, s4_wd_q;

  logic [DayW-1:0]   s5_dn_q;
  logic [C200W-1:0]  s5_c200_q;
  logic [C4W-1:0]    s5_c4_q;
  logic [WdayW-1:0]  s5_wd_q;
  logic [Rest3W-1:0] s5_rest3_d, s5_rest3_q;

  logic [DayW-1:0]   s6_dn_q;
  logic [WdayW-1:0]  s6_wd_q;
  logic [DoyW-1:0]   s6_doy_d, s6_doy_q;
  logic              s6_leap_d, s6_leap_q;
  logic [YearW-1:0]  s6_year_d, s6_year_q;

  logic [DayW-1:0]   s7_dn_q;
  logic [WdayW-1:0]  s7_wd_q;
  logic [YearW-1:0]  s7_year_q;
  logic [MonthW-1:0] s7_month_d, s7_month_q;
  logic [MdayW-1:0]  s7_mday_d, s7_mday_q;
  logic [ShortW-1:0] s7_yq_d, s7_yq_q;

  logic [DayW-1:0]   s8_dn_q;
  logic [WdayW-1:0]  s8_wd_q;
  logic [YearW-1:0]  s8_year_q;
  logic [MonthW-1:0] s8_month_q;
  logic [MdayW-1:0]  s8_mday_q;
  logic [ShortW-1:0] s8_short_d, s8_short_q;

  logic [RestW+C200RecipW-1:0]  prod200;
  logic [Rest2W+C4RecipW-1:0]   prod1461;
  logic [YearW+Y100RecipW-1:0]  prod100;
  logic [WkW-1:0]               wk;
  logic [WdayW-1:0]             wfold2;
  logic [1:0]                   c1;
  logic [MonthW-1:0]            cnt;

  always_comb begin
    s1_dn_d   = (day_number_i > LastDay) ? LastDay : day_number_i;
    s1_rest_d = RestW'(s1_dn_d) + RestW'(YearBias);

    prod200   = s1_rest_q * C200RecipW'(C200Recip);
    s2_c200_d = prod200[C200Shift +: C200W];
    wk        = WkW'(s1_dn_q) + WkW'(WeekStart);
    s2_wsum_d = '0;
    for (int i = 0; i < OctDigits; i++) begin
      s2_wsum_d = s2_wsum_d + WsumW'(wk[3*i +: 3]);
    end

    s3_rest2_d = Rest2W'(s2_rest_q - RestW'(s2_c200_q) * RestW'(Days200));
    s3_wfold_d = 4'(s2_wsum_q[5:3]) + 4'(s2_wsum_q[2:0]);

    prod1461 = s3_rest2_q * C4RecipW'(C4Recip);
    s4_c4_d  = prod1461[C4Shift +: C4W];
    wfold2   = WdayW'(s3_wfold_q[3]) + s3_wfold_q[2:0];
    s4_wd_d  = (wfold2 == 3'd7) ? '0 : wfold2;

    s5_rest3_d = Rest3W'(s4_rest2_q - Rest2W'(s4_c4_q) * Rest2W'(Days4));

    if (s5_rest3_q >= Rest3W'(3 * Days1)) begin
      c1 = 2'd3;
    end else if (s5_rest3_q >= Rest3W'(2 * Days1)) begin
      c1 = 2'd2;
    end else if (s5_rest3_q >= Rest3W'(Days1)) begin
      c1 = 2'd1;
    end else begin
      c1 = 2'd0;
    end
    s6_doy_d  = DoyW'(s5_rest3_q - Rest3W'(c1) * Rest3W'(Days1));
    s6_leap_d = (c1 == 2'd3) && (s5_c4_q != C4W'(Days200 / Days4));
    s6_year_d = YearW'(YearCalcW'(s5_c200_q) * YearCalcW'(YearsPerCycle)
                       + YearCalcW'(s5_c4_q) * YearCalcW'(YearsPerLeap)
                       + YearCalcW'(c1) - YearCalcW'(ShiftYears));

    cnt = '0;
    for (int k = 1; k < MonthsPerYear; k++) begin
      if (s6_doy_q >= cum_days(s6_leap_q, MonthW'(k))) begin
        cnt = cnt + 4'd1;
      end
    end
    s7_month_d = cnt + 4'd1;
    s7_mday_d  = MdayW'(s6_doy_q - cum_days(s6_leap_q, cnt) + 9'd1);
    prod100    = s6_year_q * Y100RecipW'(Y100Recip);
    s7_yq_d    = prod100[Y100Shift +: ShortW];

    s8_short_d = ShortW'(s7_year_q - YearW'(s7_yq_q) * YearW'(YearsPerCentury));
  end

  always_ff @(posedge clk_i) begin
    s1_dn_q    <= s1_dn_d;
    s1_rest_q  <= s1_rest_d;

    s2_dn_q    <= s1_dn_q;
    s2_rest_q  <= s1_rest_q;
    s2_c200_q  <= s2_c200_d;
    s2_wsum_q  <= s2_wsum_d;

    s3_dn_q    <= s2_dn_q;
    s3_c200_q  <= s2_c200_q;
    s3_rest2_q <= s3_rest2_d;
    s3_wfold_q <= s3_wfold_d;

    s4_dn_q    <= s3_dn_q;
    s4_c200_q  <= s3_c200_q;
    s4_rest2_q <= s3_rest2_q;
    s4_c4_q    <= s4_c4_d;
    s4_wd_q    <= s4_wd_d;

    s5_dn_q    <= s4_dn_q;
    s5_c200_q  <= s4_c200_q;
    s5_c4_q    <= s4_c4_q;
    s5_wd_q    <= s4_wd_q;
    s5_rest3_q <= s5_rest3_d;

    s6_dn_q    <= s5_dn_q;
    s6_wd_q    <= s5_wd_q;
    s6_doy_q   <= s6_doy_d;
    s6_leap_q  <= s6_leap_d;
    s6_year_q  <= s6_year_d;

    s7_dn_q    <= s6_dn_q;
    s7_wd_q    <= s6_wd_q;
    s7_year_q  <= s6_year_q;
    s7_month_q <= s7_month_d;
    s7_mday_q  <= s7_mday_d;
    s7_yq_q    <= s7_yq_d;

    s8_dn_q    <= s7_dn_q;
    s8_wd_q    <= s7_wd_q;
    s8_year_q  <= s7_year_q;
    s8_month_q <= s7_month_q;
    s8_mday_q  <= s7_mday_q;
    s8_short_q <= s8_short_d;
  end

  assign date_o = '{
    day_count:  s8_dn_q,
    year:       s8_year_q,
    month:      s8_month_q,
    mday:       s8_mday_q,
    short_year: s8_short_q,
    weekday:    s8_wd_q
  };

endmodule

`default_nettype wire

/* rtl/core/cdn_encode.sv */
`default_nettype none

module cdn_encode
  import cdn_pkg::*;
#(
  parameter int unsigned MaxYear = 9999
) (
  input  logic                    clk_i,
  input  logic [YearW-1:0]        year_in_i,
  input  logic [ShortYearInW-1:0] short_year_in_i,
  input  logic [MonthW-1:0]       month_in_i,
  input  logic [MdayW-1:0]        mday_in_i,
  output cdn_days_t               days_o
);

  localparam int unsigned MaxYearCmpW = 17;
  localparam int unsigned S365W       = 23;
  localparam int unsigned RemW        = 8;
  localparam int unsigned TotW        = 25;
  localparam int unsigned EncDelay    = DecStages - EncStages;

  logic [YearW-1:0]      yf;
  logic [YearW-1:0]      e1_year_d, e1_year_q;
  logic [MonthW-1:0]     e1_mon_d, e1_mon_q;
  logic [MdayW-1:0]      e1_mday_q;

  logic [ShiftYearW-1:0] s_sum;
  logic [ShiftYearW+Y200RecipW-1:0] prod200;
  logic [ShiftYearW-1:0] e2_s_q;
  logic [Q200W-1:0]      e2_q_d, e2_q_q;
  logic [S365W-1:0]      e2_s365_d, e2_s365_q;
  logic [YearW-1:0]      e2_year_q;
  logic [MonthW-1:0]     e2_mon_q;
  logic [MdayW-1:0]      e2_mday_q;

  logic [RemW-1:0]       rem;
  logic [S365W-1:0]      e3_ys_d, e3_ys_q;
  logic                  e3_leap_d, e3_leap_q;
  logic [YearW-1:0]      e3_year_q;
  logic [MonthW-1:0]     e3_mon_q;
  logic [MdayW-1:0]      e3_mday_q;

  logic [TotW-1:0]       tot, tot_m1;
  cdn_days_t             e4_d, e4_q;
  cdn_days_t             dly_q [EncDelay];

  always_comb begin
    yf = ((year_in_i == '0) && (short_year_in_i != '0))
         ? YearW'(CenturyBase) + YearW'(short_year_in_i) : year_in_i;
    e1_year_d = (MaxYearCmpW'(yf) > MaxYearCmpW'(MaxYear)) ? YearW'(MaxYear) : yf;
    if (month_in_i == '0) begin
      e1_mon_d = 4'd1;
    end else if (month_in_i > MonthW'(MonthsPerYear + 1)) begin
      e1_mon_d = MonthW'(MonthsPerYear + 1);
    end else begin
      e1_mon_d = month_in_i;
    end

    s_sum     = ShiftYearW'(e1_year_q) + ShiftYearW'(ShiftYears);
    prod200   = s_sum * Y200RecipW'(Y200Recip);
    e2_q_d    = prod200[Y200Shift +: Q200W];
    e2_s365_d = S365W'(s_sum) * S365W'(Days1);

    e3_ys_d   = e2_s365_q + S365W'(e2_s_q >> 2) - S365W'(e2_q_q) - S365W'(YearBias);
    rem       = RemW'(e2_s_q - ShiftYearW'(e2_q_q) * ShiftYearW'(YearsPerCycle));
    e3_leap_d = (e2_year_q[1:0] == 2'b00) && (rem != RemW'(ShiftYears));

    tot    = TotW'(e3_ys_q) + TotW'(cum_days(e3_leap_q, e3_mon_q - 4'd1)) + TotW'(e3_mday_q);
    tot_m1 = tot - TotW'(1);
    e4_d.year = e3_year_q;
    if (tot == '0) begin
      e4_d.day_count = '0;
    end else if (tot_m1 > TotW'(DayMax)) begin
      e4_d.day_count = DayMax;
    end else begin
      e4_d.day_count = tot_m1[DayW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    e1_year_q <= e1_year_d;
    e1_mon_q  <= e1_mon_d;
    e1_mday_q <= mday_in_i;

    e2_s_q    <= s_sum;
    e2_q_q    <= e2_q_d;
    e2_s365_q <= e2_s365_d;
    e2_year_q <= e1_year_q;
    e2_mon_q  <= e1_mon_q;
    e2_mday_q <= e1_mday_q;

    e3_ys_q   <= e3_ys_d;
    e3_leap_q <= e3_leap_d;
    e3_year_q <= e2_year_q;
    e3_mon_q  <= e2_mon_q;
    e3_mday_q <= e2_mday_q;

    e4_q      <= e4_d;
    dly_q[0]  <= e4_q;
    for (int i = 1; i < EncDelay; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign days_o = dly_q[EncDelay-1];

endmodule

`default_nettype wire

/* rtl/core/cdn_checker.sv */
`default_nettype none

`include "calendar_day_number_converter_top_assert.svh"

module cdn_checker
  import cdn_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              kind_i,
  input logic              done_o,
  input logic [MonthW-1:0] month_out_o,
  input logic [MdayW-1:0]  mday_out_o,
  input logic [ShortW-1:0] short_year_out_o,
  input logic [WdayW-1:0]  weekday_o
);

  logic enc_fields_zero;
  logic dec_fields_ok;

  assign enc_fields_zero = (month_out_o == '0) && (mday_out_o == '0)
                           && (short_year_out_o == '0) && (weekday_o == '0);
  assign dec_fields_ok   = (month_out_o != '0) && (month_out_o <= MonthW'(MonthsPerYear))
                           && (mday_out_o != '0) && (weekday_o != '1);

  `CDN_ASSERT_ALWAYS(a_never_busy, !busy_o)
  `CDN_ASSERT_IMP(a_fixed_latency, start_i, ##Latency done_o)
  `CDN_ASSERT_IMP(a_no_spurious_done, done_o, $past(start_i, Latency))
  `CDN_ASSERT_IMP(a_encode_zero_fields, done_o && $past(kind_i, Latency), enc_fields_zero)
  `CDN_ASSERT_IMP(a_decode_ranges, done_o && !$past(kind_i, Latency), dec_fields_ok)

endmodule

bind calendar_day_number_converter_top cdn_checker u_cdn_checker (.*);

`default_nettype wire

/* tb/tb_calendar_day_number_converter_top.sv */
`timescale 1ns / 100ps

module tb_calendar_day_number_converter_top;
  import cdn_pkg::*;

  localparam int unsigned MaxYearLimit  = 9999;
  localparam int unsigned CycleDays     = 73049;
  localparam int unsigned QuadDays      = 1461;
  localparam int unsigned YearDays      = 365;
  localparam int unsigned YearOffset    = 199;
  localparam int unsigned ShortYearBase = 1900;
  localparam int unsigned WatchdogLimit = 500;

  typedef struct {
    cdn_kind_e               kind;
    logic [DayW-1:0]         day_number;
    logic [YearW-1:0]        year_in;
    logic [ShortYearInW-1:0] short_year_in;
    logic [MonthW-1:0]       month_in;
    logic [MdayW-1:0]        mday_in;
    int unsigned             gap;
    bit                      drain;
  } cal_cmd_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic                    kind_i = 1'b0;
  logic [DayW-1:0]         day_number_i = '0;
  logic [YearW-1:0]        year_in_i = '0;
  logic [ShortYearInW-1:0] short_year_in_i = '0;
  logic [MonthW-1:0]       month_in_i = '0;
  logic [MdayW-1:0]        mday_in_i = '0;
  logic                    done_o;
  logic [DayW-1:0]         day_count_o;
  logic [YearW-1:0]        year_out_o;
  logic [MonthW-1:0]       month_out_o;
  logic [MdayW-1:0]        mday_out_o;
  logic [ShortW-1:0]       short_year_out_o;
  logic [WdayW-1:0]        weekday_o;

  cal_cmd_t    pending_cmds[$];
  cdn_date_t   expected_dates[$];
  cal_cmd_t    cur_cmd;
  logic        cmd_taken = 1'b0;
  int unsigned idle_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_to_date = 0;
  int unsigned n_to_days = 0;
  int unsigned n_pause_cycles = 0;
  bit          burst_mode = 1'b0;
  bit          next_drain = 1'b0;

  calendar_day_number_converter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .day_number_i     (day_number_i),
    .year_in_i        (year_in_i),
    .short_year_in_i  (short_year_in_i),
    .month_in_i       (month_in_i),
    .mday_in_i        (mday_in_i),
    .done_o           (done_o),
    .day_count_o      (day_count_o),
    .year_out_o       (year_out_o),
    .month_out_o      (month_out_o),
    .mday_out_o       (mday_out_o),
    .short_year_out_o (short_year_out_o),
    .weekday_o        (weekday_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned first_day_of_year(longint unsigned yr);
    longint unsigned s;
    s = yr + YearOffset;
    return s * YearDays + s / 4 - s / 200 - (CycleDays - YearDays);
  endfunction

  function automatic int unsigned month_days(bit leap, int unsigned idx);
    int unsigned lens[12];
    lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return lens[idx] + ((leap && idx == 1) ? 1 : 0);
  endfunction

  function automatic cdn_date_t predict_result(cal_cmd_t c);
    cdn_date_t       r;
    longint unsigned dn, rest, c200, c4, c1, doy, yr, last_day;
    longint signed   total;
    int unsigned     mon, mon_eff;
    bit              leap;
    r = '0;
    if (c.kind == KindToDate) begin
      last_day = first_day_of_year(MaxYearLimit + 1) - 1;
      dn = c.day_number;
      if (dn > last_day) dn = last_day;
      rest = dn + (CycleDays - YearDays);
      c200 = rest / CycleDays;
      rest -= c200 * CycleDays;
      c4 = rest / QuadDays;
      rest -= c4 * QuadDays;
      c1 = rest / YearDays;
      if (c1 > 3) c1 = 3;
      doy = rest - c1 * YearDays;
      yr = c200 * 200 + c4 * 4 + c1 - YearOffset;
      leap = (c1 == 3) && (c4 != 49);
      mon = 0;
      while (mon < 11 && doy >= month_days(leap, mon)) begin
        doy -= month_days(leap, mon);
        mon++;
      end
      r.day_count  = dn[DayW-1:0];
      r.year       = yr[YearW-1:0];
      r.month      = MonthW'(mon + 1);
      r.mday       = MdayW'(doy + 1);
      r.short_year = ShortW'(yr % 100);
      r.weekday    = WdayW'((dn + 1) % 7);
    end else begin
      yr = c.year_in;
      if (yr == 0 && c.short_year_in != 0) yr = ShortYearBase + c.short_year_in;
      if (yr > MaxYearLimit) yr = MaxYearLimit;
      mon_eff = c.month_in;
      if (mon_eff == 0) mon_eff = 1;
      if (mon_eff > 13) mon_eff = 13;
      leap = (yr % 4 == 0) && (yr % 200 != 0);
      total = longint'(first_day_of_year(yr));
      for (int i = 0; i < int'(mon_eff) - 1; i++) total += month_days(leap, i);
      total += longint'(c.mday_in) - 1;
      if (total < 0) total = 0;
      if (total > longint'(DayMax)) total = longint'(DayMax);
      r.day_count = total[DayW-1:0];
      r.year      = yr[YearW-1:0];
    end
    return r;
  endfunction

  task automatic queue_cmd(cdn_kind_e kind, logic [DayW-1:0] dn, logic [YearW-1:0] yr,
                           logic [ShortYearInW-1:0] sy, logic [MonthW-1:0] mo,
                           logic [MdayW-1:0] md);
    cal_cmd_t    c;
    int unsigned r;
    c.kind = kind;
    c.day_number = dn;
    c.year_in = yr;
    c.short_year_in = sy;
    c.month_in = mo;
    c.mday_in = md;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) c.gap = 0;
    else if (r < 90) c.gap = $urandom_range(1, 3);
    else c.gap = $urandom_range(8, 40);
    c.drain = next_drain;
    next_drain = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_decode();
    longint unsigned dn, base;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      dn = 64'($urandom_range(0, 32'(first_day_of_year(MaxYearLimit + 1) - 1)));
    end else if (pick < 8) begin
      base = first_day_of_year(64'($urandom_range(0, MaxYearLimit)));
      if (base > 0) base--;
      dn = base + 64'($urandom_range(0, 61));
    end else if (pick == 8) begin
      dn = first_day_of_year(MaxYearLimit + 1) - 70 + 64'($urandom_range(0, 140));
    end else begin
      dn = 64'($urandom);
    end
    queue_cmd(KindToDate, dn[DayW-1:0], YearW'($urandom), ShortYearInW'($urandom),
              MonthW'($urandom), MdayW'($urandom));
  endtask

  task automatic add_random_encode();
    logic [YearW-1:0]  yr;
    logic [MonthW-1:0] mo;
    logic [MdayW-1:0]  md;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) yr = YearW'($urandom_range(1, MaxYearLimit));
    else if (pick < 8) yr = '0;
    else yr = YearW'($urandom);
    if ($urandom_range(0, 9) < 8) mo = MonthW'($urandom_range(1, 12));
    else mo = MonthW'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 8) md = MdayW'($urandom_range(1, 31));
    else md = MdayW'($urandom_range(0, 31));
    queue_cmd(KindToDays, DayW'($urandom), yr, ShortYearInW'($urandom_range(0, 127)), mo, md);
  endtask

  task automatic check_field(string fname, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
      n_errors++;
    end
  endtask

  // Driver: a command holds until the block takes it, then the next one follows its gap.
  always @(negedge clk_i) begin
    cal_cmd_t head;
    if (rst_ni && !(start_i && !cmd_taken)) begin
      if (pending_cmds.size() == 0) begin
        start_i <= 1'b0;
      end else begin
        head = pending_cmds[0];
        if (idle_cnt < head.gap || (head.drain && expected_dates.size() != 0)) begin
          if (idle_cnt < head.gap) idle_cnt++;
          else n_pause_cycles++;
          start_i <= 1'b0;
        end else begin
          void'(pending_cmds.pop_front());
          cur_cmd = head;
          idle_cnt = 0;
          start_i         <= 1'b1;
          kind_i          <= head.kind;
          day_number_i    <= head.day_number;
          year_in_i       <= head.year_in;
          short_year_in_i <= head.short_year_in;
          month_in_i      <= head.month_in;
          mday_in_i       <= head.mday_in;
        end
      end
    end
  end

  // Monitor: checks each result transfer and records the expectation of each command taken.
  always @(posedge clk_i) begin
    cdn_date_t want;
    if (!rst_ni) begin
      cmd_taken = 1'b0;
      stall_cycles = 0;
    end else begin
      cmd_taken = start_i && !busy_o;
      if (done_o) begin
        n_results++;
        if (expected_dates.size() == 0) begin
          $error("unexpected result: day_count %0d, year %0d", day_count_o, year_out_o);
          n_errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("day_count", want.day_count, day_count_o);
          check_field("year_out", want.year, year_out_o);
          check_field("month_out", want.month, month_out_o);
          check_field("mday_out", want.mday, mday_out_o);
          check_field("short_year_out", want.short_year, short_year_out_o);
          check_field("weekday", want.weekday, weekday_o);
        end
      end
      if (cmd_taken) begin
        expected_dates.push_back(predict_result(cur_cmd));
        if (cur_cmd.kind == KindToDate) n_to_date++;
        else n_to_days++;
      end
      if (cmd_taken || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("timeout with %0d results outstanding", expected_dates.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    queue_cmd(KindToDate, 22'd0, '0, '0, '0, '0);
    queue_cmd(KindToDate, 22'd59, '0, '0, '0, '0);
    queue_cmd(KindToDate, DayW'(first_day_of_year(4) + 59), '0, '0, '0, '0);
    queue_cmd(KindToDate, DayW'(first_day_of_year(200) + 59), '0, '0, '0, '0);
    queue_cmd(KindToDate, DayW'(first_day_of_year(2000) - 1), '0, '0, '0, '0);
    queue_cmd(KindToDate, DayW'(first_day_of_year(MaxYearLimit + 1) - 1), '0, '0, '0, '0);
    queue_cmd(KindToDate, DayW'(first_day_of_year(MaxYearLimit + 1)), '0, '0, '0, '0);
    queue_cmd(KindToDate, DayMax, '1, '1, '1, '1);
    queue_cmd(KindToDate, 22'h2AAAAA, '0, '0, '0, '0);
    queue_cmd(KindToDate, 22'h155555, '0, '0, '0, '0);
    queue_cmd(KindToDays, '0, 14'd0, 7'd0, 4'd1, 5'd1);
    queue_cmd(KindToDays, '0, 14'd0, 7'd0, 4'd1, 5'd0);
    queue_cmd(KindToDays, '0, 14'd0, 7'd99, 4'd1, 5'd1);
    queue_cmd(KindToDays, '0, 14'd0, 7'd127, 4'd12, 5'd31);
    queue_cmd(KindToDays, '0, 14'd0, 7'd1, 4'd2, 5'd29);
    queue_cmd(KindToDays, '0, 14'd9999, 7'd0, 4'd12, 5'd31);
    queue_cmd(KindToDays, DayMax, 14'h3FFF, 7'h7F, 4'hF, 5'd31);
    queue_cmd(KindToDays, '0, 14'd10000, 7'd0, 4'd1, 5'd1);
    queue_cmd(KindToDays, '0, 14'd4, 7'd0, 4'd2, 5'd29);
    queue_cmd(KindToDays, '0, 14'd200, 7'd0, 4'd3, 5'd1);
    queue_cmd(KindToDays, '0, 14'd2024, 7'd0, 4'd0, 5'd15);
    queue_cmd(KindToDays, '0, 14'd2024, 7'd0, 4'd13, 5'd0);
    queue_cmd(KindToDays, '0, 14'd1999, 7'd55, 4'd14, 5'd31);
    queue_cmd(KindToDays, 22'h2AAAAA, 14'h2AAA, 7'h55, 4'hA, 5'h15);
    for (int blk = 0; blk < 27; blk++) begin
      burst_mode = (blk % 4 == 1);
      if (blk % 6 == 3) next_drain = 1'b1;
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 1) == 0) add_random_decode();
        else add_random_encode();
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i || expected_dates.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    $display("Checked %0d results: %0d day-number decodes and %0d date encodes.",
             n_results, n_to_date, n_to_days);
    $display("Included saturating inputs, random gaps and %0d cycles paused for an empty pipe.",
             n_pause_cycles);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* calendar_day_number_converter_top.f */
+incdir+rtl/core
rtl/core/cdn_pkg.sv
rtl/core/cdn_decode.sv
rtl/core/cdn_encode.sv
rtl/core/calendar_day_number_converter_top.sv
rtl/core/cdn_checker.sv
tb/tb_calendar_day_number_converter_top.sv
